[design/lfs_pkg.sv]
// lfs_pkg: shared types and constants of the line follow steering block
// no dependencies; imported by lfs_filter, lfs_map, line_follow_steering and the testbench
package lfs_pkg;

    localparam int MASK_W  = 4;
    localparam int LEVEL_W = 13;
    localparam int CNT_W   = 2;

    typedef logic [MASK_W-1:0]         mask_t;
    typedef logic signed [LEVEL_W-1:0] level_t;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        VARIANT_NORMAL = 2'd0,
        VARIANT_ARC    = 2'd1,
        VARIANT_SLOW   = 2'd2
    } variant_t;

    typedef enum logic [2:0] {
        MODE_STOP   = 3'd0,
        MODE_TRACK  = 3'd1,
        MODE_TURN   = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_WIDE   = 3'd4
    } mode_t;

    // wheel drive levels
    localparam level_t LVL_ZERO     = 13'sd0;
    localparam level_t LVL_STRAIGHT = 13'sd2400;
    localparam level_t LVL_SLOW     = 13'sd2200;
    localparam level_t LVL_OUTER    = 13'sd2600;
    localparam level_t LVL_TURN     = 13'sd2700;
    localparam level_t LVL_TURN_NEG = -13'sd2700;
    localparam level_t LVL_GENTLE   = 13'sd2300;
    localparam level_t LVL_INSIDE   = 13'sd800;

    // one steering decision: mode, wheel levels and remembered side
    typedef struct packed {
        mode_t  mode;
        level_t left;
        level_t right;
        logic   side_right;
    } drive_t;

endpackage

[design/lfs_filter.sv]
// lfs_filter: agreement filter on the raw sensor mask, holds its own state
// depends on lfs_pkg
module lfs_filter #(
    parameter int AGREE_SAMPLES = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          update,
    input  logic          clear,
    input  lfs_pkg::mask_t raw,
    output lfs_pkg::mask_t filt_next
);
    import lfs_pkg::*;

    localparam logic [CNT_W-1:0] AGREE_CNT = CNT_W'(AGREE_SAMPLES);

    mask_t            candidate_reg, candidate_next;
    mask_t            filtered_reg, filtered_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             primed_reg, primed_next;

    always_comb
    begin
        candidate_next = candidate_reg;
        filtered_next  = filtered_reg;
        count_next     = count_reg;
        primed_next    = primed_reg;
        if (!primed_reg)
        begin
            candidate_next = raw;
            filtered_next  = raw;
            count_next     = CNT_W'(1);
            primed_next    = 1'b1;
        end
        else if (raw != candidate_reg)
        begin
            candidate_next = raw;
            count_next     = CNT_W'(1);
        end
        else if (count_reg < AGREE_CNT)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (count_next >= AGREE_CNT)
            filtered_next = candidate_next;
    end

    assign filt_next = filtered_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidate_reg <= '0;
            filtered_reg  <= '0;
            count_reg     <= '0;
            primed_reg    <= 1'b0;
        end
        else if (clear)
        begin
            candidate_reg <= '0;
            filtered_reg  <= '0;
            count_reg     <= '0;
            primed_reg    <= 1'b0;
        end
        else if (update)
        begin
            candidate_reg <= candidate_next;
            filtered_reg  <= filtered_next;
            count_reg     <= count_next;
            primed_reg    <= primed_next;
        end
    end

endmodule

[design/lfs_map.sv]
// lfs_map: maps the filtered pattern and raw sample to mode and wheel levels
// depends on lfs_pkg; purely combinational
module lfs_map (
    input  logic [1:0]      variant,
    input  lfs_pkg::mask_t  raw,
    input  lfs_pkg::mask_t  filt,
    input  logic            side_now,
    output lfs_pkg::drive_t result
);
    import lfs_pkg::*;

    mask_t v;

    always_comb
    begin
        v = (raw == '0) ? '0 : filt;
        result.mode       = MODE_WIDE;
        result.left       = LVL_SLOW;
        result.right      = LVL_SLOW;
        result.side_right = side_now;

        case (v) inside
            4'd6:
            begin
                result.mode  = MODE_TRACK;
                result.left  = LVL_STRAIGHT;
                result.right = LVL_STRAIGHT;
            end
            4'd4:
            begin
                result.mode       = MODE_TRACK;
                result.left       = LVL_SLOW;
                result.right      = LVL_OUTER;
                result.side_right = 1'b0;
            end
            4'd2:
            begin
                result.mode       = MODE_TRACK;
                result.left       = LVL_OUTER;
                result.right      = LVL_SLOW;
                result.side_right = 1'b1;
            end
            4'd8, 4'd12:
            begin
                result.mode       = MODE_TURN;
                result.left       = LVL_TURN_NEG;
                result.right      = LVL_TURN;
                result.side_right = 1'b0;
            end
            4'd1, 4'd3:
            begin
                result.mode       = MODE_TURN;
                result.left       = LVL_TURN;
                result.right      = LVL_TURN_NEG;
                result.side_right = 1'b1;
            end
            4'd0:
            begin
                // line lost: spin toward the remembered side
                result.mode  = MODE_SEARCH;
                result.left  = side_now ? LVL_TURN : LVL_TURN_NEG;
                result.right = side_now ? LVL_TURN_NEG : LVL_TURN;
            end
            default:
            begin
                result.mode  = MODE_WIDE;
                result.left  = LVL_SLOW;
                result.right = LVL_SLOW;
            end
        endcase

        // overrides work on the raw sample
        if (raw != '0)
        begin
            case (variant)
                VARIANT_ARC:
                begin
                    result.mode = MODE_TRACK;
                    case (raw) inside
                        4'd8, 4'd12, 4'd4:
                        begin
                            result.left       = LVL_SLOW;
                            result.right      = LVL_OUTER;
                            result.side_right = 1'b0;
                        end
                        4'd1, 4'd3, 4'd2:
                        begin
                            result.left       = LVL_OUTER;
                            result.right      = LVL_SLOW;
                            result.side_right = 1'b1;
                        end
                        default:
                        begin
                            result.left  = LVL_SLOW;
                            result.right = LVL_SLOW;
                        end
                    endcase
                end
                VARIANT_SLOW:
                begin
                    result.mode = MODE_TRACK;
                    case (raw) inside
                        4'd4:
                        begin
                            result.left       = LVL_SLOW;
                            result.right      = LVL_GENTLE;
                            result.side_right = 1'b0;
                        end
                        4'd2:
                        begin
                            result.left       = LVL_GENTLE;
                            result.right      = LVL_SLOW;
                            result.side_right = 1'b1;
                        end
                        4'd8, 4'd12:
                        begin
                            result.left       = LVL_INSIDE;
                            result.right      = LVL_GENTLE;
                            result.side_right = 1'b0;
                        end
                        4'd1, 4'd3:
                        begin
                            result.left       = LVL_GENTLE;
                            result.right      = LVL_INSIDE;
                            result.side_right = 1'b1;
                        end
                        4'd6:
                        begin
                            result.left  = LVL_GENTLE;
                            result.right = LVL_GENTLE;
                        end
                        default:
                        begin
                            result.mode  = MODE_WIDE;
                            result.left  = LVL_GENTLE;
                            result.right = LVL_GENTLE;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

[design/line_follow_steering.sv]
// line_follow_steering: top level of the line follow steering block
// depends on lfs_pkg, lfs_filter and lfs_map
//
// usage:
//   input channel (in_valid/in_ready) carries one request: command and
//   sample_mask. a sample runs the agreement filter and, outside stop mode,
//   the steering tables; start enters track mode from stop; stop halts.
//   output channel (out_valid/out_ready) returns one result per request:
//   drive_mode, left_drive and right_drive as held after that request.
//   cfg_write_en/cfg_write_data write the steering variant at any edge;
//   write it only while no request is in flight.
// pipeline and throughput:
//   a request is registered in the input register on acceptance; once the
//   output register is empty or being taken, the request is processed and
//   its result is registered there, raising out_valid. one request per cycle
//   is sustained while out_ready stays high; the filter and mode state feed
//   back through a single register stage, which sets that figure.
// reset:
//   mode stop, levels zero, filter empty, side left, variant normal, both
//   pipeline stages empty.
// stall:
//   a stalled result holds; one more request waits in the input register,
//   then in_ready drops until out_ready returns.
module line_follow_steering #(
    parameter int AGREE_SAMPLES = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    input  lfs_pkg::mask_t         sample_mask,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             drive_mode,
    output lfs_pkg::level_t        left_drive,
    output lfs_pkg::level_t        right_drive,
    input  logic                   cfg_write_en,
    input  logic [1:0]             cfg_write_data
);
    import lfs_pkg::*;

    logic [1:0] variant_reg;

    logic       in_valid_reg, in_valid_next;
    logic [1:0] cmd_reg;
    mask_t      mask_reg;

    logic       out_valid_reg, out_valid_next;
    mode_t      mode_reg, mode_next;
    level_t     left_reg, left_next;
    level_t     right_reg, right_next;
    logic       side_reg, side_next;

    logic       advance;
    logic       fire;
    logic       filt_update;
    logic       filt_clear;
    mask_t      filt_next;
    drive_t     mapped;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign filt_update = fire && (cmd_reg == CMD_SAMPLE);
    assign filt_clear  = fire && (cmd_reg == CMD_START) && (mode_reg == MODE_STOP);

    lfs_filter #(
        .AGREE_SAMPLES(AGREE_SAMPLES)
    ) u_filter (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (filt_update),
        .clear    (filt_clear),
        .raw      (mask_reg),
        .filt_next(filt_next)
    );

    lfs_map u_map (
        .variant (variant_reg),
        .raw     (mask_reg),
        .filt    (filt_next),
        .side_now(side_reg),
        .result  (mapped)
    );

    always_comb
    begin
        mode_next  = mode_reg;
        left_next  = left_reg;
        right_next = right_reg;
        side_next  = side_reg;
        case (cmd_reg)
            CMD_START:
            begin
                if (mode_reg == MODE_STOP)
                begin
                    mode_next  = MODE_TRACK;
                    left_next  = LVL_ZERO;
                    right_next = LVL_ZERO;
                    side_next  = 1'b0;
                end
            end
            CMD_STOP:
            begin
                mode_next  = MODE_STOP;
                left_next  = LVL_ZERO;
                right_next = LVL_ZERO;
            end
            CMD_SAMPLE:
            begin
                // in stop mode only the filter moves
                if (mode_reg != MODE_STOP)
                begin
                    mode_next  = mapped.mode;
                    left_next  = mapped.left;
                    right_next = mapped.right;
                    side_next  = mapped.side_right;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_STOP;
            left_reg      <= LVL_ZERO;
            right_reg     <= LVL_ZERO;
            side_reg      <= 1'b0;
            variant_reg   <= VARIANT_NORMAL;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                mode_reg  <= mode_next;
                left_reg  <= left_next;
                right_reg <= right_next;
                side_reg  <= side_next;
            end
            if (cfg_write_en)
                variant_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= command;
            mask_reg <= sample_mask;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_mode  = mode_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;

    // stop mode always reports zero levels
    a_stop_levels_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_STOP) |-> (left_reg == LVL_ZERO && right_reg == LVL_ZERO))
        else $error("stop mode with nonzero drive levels");

    // search and turn always spin in place
    a_spin_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SEARCH || mode_reg == MODE_TURN) |-> (left_reg == -right_reg))
        else $error("spin with unbalanced wheel levels");

    // a processed request always leaves a result behind
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed request produced no result");

    // a waiting request is kept while the result side stalls
    a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(mask_reg) && $stable(cmd_reg)))
        else $error("stalled request lost");

    // state only moves when a request is processed
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(mode_reg) && $stable(left_reg)))
        else $error("state changed without a request");

endmodule

[sim/tb_line_follow_steering.sv]
// tb_line_follow_steering: self-checking testbench for the line follow steering block
// drives commands and sensor masks with random idling, predicts mode and wheel levels
// depends on lfs_pkg and line_follow_steering
module tb_line_follow_steering;
    import lfs_pkg::*;

    localparam int AGREE_SAMPLES = 2;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct {
        cmd_t  cmd;
        mask_t mask;
    } request_t;

    typedef struct {
        mode_t  mode;
        level_t left;
        level_t right;
    } drive_rec_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] command = CMD_SAMPLE;
    mask_t      sample_mask = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] drive_mode;
    level_t     left_drive;
    level_t     right_drive;
    logic       cfg_write_en = 1'b0;
    logic [1:0] cfg_write_data = VARIANT_NORMAL;

    request_t   request_q[$];
    drive_rec_t pending_drive_q[$];
    request_t   cur_req;
    int         mismatches = 0;
    int         drive_seen = 0;
    int         cycles = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         hold_left = 0;
    bit         long_hold_done = 1'b0;
    bit         calm = 1'b0;
    mask_t      line_mask = '0;

    // predicted block state
    variant_t   variant;
    mask_t      cand_bits;
    mask_t      filt_bits;
    logic [1:0] agree_cnt;
    bit         primed;
    bit         side_right;
    mode_t      steer_mode;
    level_t     steer_left;
    level_t     steer_right;

    line_follow_steering #(
        .AGREE_SAMPLES (AGREE_SAMPLES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .sample_mask    (sample_mask),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_mode     (drive_mode),
        .left_drive     (left_drive),
        .right_drive    (right_drive),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void clear_steering();
        cand_bits   = '0;
        filt_bits   = '0;
        agree_cnt   = '0;
        primed      = 1'b0;
        side_right  = 1'b0;
        steer_mode  = MODE_STOP;
        steer_left  = LVL_ZERO;
        steer_right = LVL_ZERO;
    endfunction

    function automatic void set_drive(mode_t md, level_t l, level_t r);
        steer_mode  = md;
        steer_left  = l;
        steer_right = r;
    endfunction

    // advance the steering state by one request and queue the held outputs
    function automatic void steer_step(request_t req);
        mask_t      v;
        drive_rec_t rec;
        case (req.cmd)
            CMD_START:
            begin
                if (steer_mode == MODE_STOP)
                begin
                    clear_steering();
                    steer_mode = MODE_TRACK;
                end
            end
            CMD_STOP: set_drive(MODE_STOP, LVL_ZERO, LVL_ZERO);
            CMD_SAMPLE:
            begin
                if (!primed)
                begin
                    cand_bits = req.mask;
                    filt_bits = req.mask;
                    agree_cnt = 2'd1;
                    primed    = 1'b1;
                end
                else if (req.mask != cand_bits)
                begin
                    cand_bits = req.mask;
                    agree_cnt = 2'd1;
                end
                else if (agree_cnt < AGREE_SAMPLES)
                    agree_cnt = agree_cnt + 2'd1;
                if (agree_cnt >= AGREE_SAMPLES)
                    filt_bits = cand_bits;
                // outputs hold while stopped, only the filter moves
                if (steer_mode != MODE_STOP)
                begin
                    v = (req.mask == 4'd0) ? 4'd0 : filt_bits;
                    case (v)
                        4'd6: set_drive(MODE_TRACK, LVL_STRAIGHT, LVL_STRAIGHT);
                        4'd4:
                        begin
                            side_right = 1'b0;
                            set_drive(MODE_TRACK, LVL_SLOW, LVL_OUTER);
                        end
                        4'd2:
                        begin
                            side_right = 1'b1;
                            set_drive(MODE_TRACK, LVL_OUTER, LVL_SLOW);
                        end
                        4'd8, 4'd12:
                        begin
                            side_right = 1'b0;
                            set_drive(MODE_TURN, LVL_TURN_NEG, LVL_TURN);
                        end
                        4'd1, 4'd3:
                        begin
                            side_right = 1'b1;
                            set_drive(MODE_TURN, LVL_TURN, LVL_TURN_NEG);
                        end
                        4'd0:
                        begin
                            // line lost: spin toward the remembered side
                            if (side_right)
                                set_drive(MODE_SEARCH, LVL_TURN, LVL_TURN_NEG);
                            else
                                set_drive(MODE_SEARCH, LVL_TURN_NEG, LVL_TURN);
                        end
                        default: set_drive(MODE_WIDE, LVL_SLOW, LVL_SLOW);
                    endcase
                    // override tables look at the raw sample
                    if (req.mask != 4'd0 && variant == VARIANT_ARC)
                    begin
                        case (req.mask)
                            4'd8, 4'd12, 4'd4:
                            begin
                                side_right = 1'b0;
                                set_drive(MODE_TRACK, LVL_SLOW, LVL_OUTER);
                            end
                            4'd1, 4'd3, 4'd2:
                            begin
                                side_right = 1'b1;
                                set_drive(MODE_TRACK, LVL_OUTER, LVL_SLOW);
                            end
                            default: set_drive(MODE_TRACK, LVL_SLOW, LVL_SLOW);
                        endcase
                    end
                    else if (req.mask != 4'd0 && variant == VARIANT_SLOW)
                    begin
                        case (req.mask)
                            4'd4:
                            begin
                                side_right = 1'b0;
                                set_drive(MODE_TRACK, LVL_SLOW, LVL_GENTLE);
                            end
                            4'd2:
                            begin
                                side_right = 1'b1;
                                set_drive(MODE_TRACK, LVL_GENTLE, LVL_SLOW);
                            end
                            4'd8, 4'd12:
                            begin
                                side_right = 1'b0;
                                set_drive(MODE_TRACK, LVL_INSIDE, LVL_GENTLE);
                            end
                            4'd1, 4'd3:
                            begin
                                side_right = 1'b1;
                                set_drive(MODE_TRACK, LVL_GENTLE, LVL_INSIDE);
                            end
                            4'd6: set_drive(MODE_TRACK, LVL_GENTLE, LVL_GENTLE);
                            default: set_drive(MODE_WIDE, LVL_GENTLE, LVL_GENTLE);
                        endcase
                    end
                end
            end
            default: ;
        endcase
        rec.mode  = steer_mode;
        rec.left  = steer_left;
        rec.right = steer_right;
        pending_drive_q.push_back(rec);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            command     <= CMD_SAMPLE;
            sample_mask <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                steer_step(cur_req);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    cur_req = request_q.pop_front();
                    in_valid    <= 1'b1;
                    command     <= cur_req.cmd;
                    sample_mask <= cur_req.mask;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void report(string field, int exp_val, int act_val);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, exp_val, act_val);
    endfunction

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        drive_rec_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                drive_seen++;
                if (pending_drive_q.size() == 0)
                    report("unexpected result drive_mode", -1, drive_mode);
                else
                begin
                    want = pending_drive_q.pop_front();
                    if (drive_mode !== want.mode)
                        report("drive_mode", want.mode, drive_mode);
                    if (left_drive !== want.left)
                        report("left_drive", want.left, left_drive);
                    if (right_drive !== want.right)
                        report("right_drive", want.right, right_drive);
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && drive_seen >= 300)
            begin
                // long back-pressure so the block fills and drops in_ready
                long_hold_done = 1'b1;
                hold_left = 399;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_request(cmd_t c, mask_t m);
        request_t req;
        req.cmd  = c;
        req.mask = m;
        request_q.push_back(req);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || pending_drive_q.size() != 0);
    endtask

    task automatic set_variant(variant_t v);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        variant = v;
    endtask

    // mostly tracking runs with repeated masks so the filter settles
    task automatic add_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                add_request(CMD_STOP, mask_t'($urandom_range(0, 15)));
            else if (r < 8)
                add_request(CMD_START, mask_t'($urandom_range(0, 15)));
            else
            begin
                if ($urandom_range(0, 9) >= 6)
                    line_mask = mask_t'($urandom_range(0, 15));
                add_request(CMD_SAMPLE, line_mask);
            end
        end
    endtask

    initial
    begin
        variant_t plan[8];
        plan = '{VARIANT_ARC, VARIANT_SLOW, VARIANT_NORMAL, VARIANT_ARC,
                 VARIANT_SLOW, VARIANT_NORMAL, VARIANT_SLOW, VARIANT_ARC};
        variant = VARIANT_NORMAL;
        clear_steering();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        set_variant(VARIANT_NORMAL);
        // samples and stop while stopped, then start, and a start while tracking
        add_request(CMD_SAMPLE, 4'd15);
        add_request(CMD_SAMPLE, 4'd0);
        add_request(CMD_STOP, 4'd0);
        add_request(CMD_START, 4'd15);
        add_request(CMD_START, 4'd0);
        add_request(CMD_SAMPLE, 4'd6);
        add_request(CMD_SAMPLE, 4'd4);
        add_request(CMD_SAMPLE, 4'd4);
        add_request(CMD_SAMPLE, 4'd2);
        add_request(CMD_SAMPLE, 4'd2);
        add_request(CMD_SAMPLE, 4'd8);
        add_request(CMD_SAMPLE, 4'd8);
        add_request(CMD_SAMPLE, 4'd0);
        add_request(CMD_SAMPLE, 4'd12);
        add_request(CMD_SAMPLE, 4'd12);
        add_request(CMD_SAMPLE, 4'd1);
        add_request(CMD_SAMPLE, 4'd1);
        add_request(CMD_SAMPLE, 4'd0);
        add_request(CMD_SAMPLE, 4'd3);
        add_request(CMD_SAMPLE, 4'd3);
        add_request(CMD_SAMPLE, 4'd9);
        add_request(CMD_SAMPLE, 4'd9);
        add_request(CMD_SAMPLE, 4'd15);
        add_request(CMD_STOP, 4'd15);
        add_request(CMD_SAMPLE, 4'd5);

        for (int p = 0; p < 8; p++)
        begin
            set_variant(plan[p]);
            if (p == 7)
                calm <= 1'b1;
            add_request(CMD_START, 4'd0);
            add_random(199);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_drive_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
